>>> hdl/assert_macros.svh
// Assertion shorthands shared by the converter's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define HSL_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle pipeline check failed");

// The condition must hold in the cycle after the trigger.
`define HSL_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle pipeline check failed");

`endif

>>> hdl/hsl2rgb_pkg.sv
`default_nettype none

package hsl2rgb_pkg;

    // Which piece of the hue ramp a channel position falls on.
    typedef enum logic [1:0] {
        SEL_RAMP,
        SEL_HIGH,
        SEL_LOW
    } ramp_sel_t;

    // Stage loads for the ramp section (stages two and three).
    typedef struct packed {
        logic load_mul;
        logic load_level;
    } ramp_ctl_t;

    // Stage loads for the scaling section (stages four to six), plus the
    // valid flag of stage five, which feeds the correction step.
    typedef struct packed {
        logic load_prod;
        logic load_est;
        logic load_out;
        logic est_valid;
    } scale_ctl_t;

endpackage

`default_nettype wire

>>> hdl/hsl2rgb_front.sv
`default_nettype none

module hsl2rgb_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic [FRAC_BITS-1:0]   hue,
    input  logic [FRAC_BITS-1:0]   saturation,
    input  logic [FRAC_BITS-1:0]   lightness,
    output logic [2*FRAC_BITS-1:0] st,
    output logic [2*FRAC_BITS-1:0] lm,
    output logic [FRAC_BITS+1:0]   pos_red,
    output logic [FRAC_BITS+1:0]   pos_green,
    output logic [FRAC_BITS+1:0]   pos_blue
);

    localparam logic [FRAC_BITS-1:0] FULL     = '1;
    localparam logic [FRAC_BITS+2:0] UNIT     = {3'b001, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+2:0] UNIT_TWO = {3'b010, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS+2:0] SPAN     = {3'b011, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS-1:0]   fold;
    logic [2*FRAC_BITS-1:0] st_next;
    logic [2*FRAC_BITS-1:0] lm_next;
    logic [FRAC_BITS+2:0]   green_wide;
    logic [FRAC_BITS+2:0]   red_wide;
    logic [FRAC_BITS+2:0]   blue_wide;
    logic [FRAC_BITS+2:0]   red_wrap;
    logic [FRAC_BITS+2:0]   blue_wrap;

    logic [2*FRAC_BITS-1:0] st_reg;
    logic [2*FRAC_BITS-1:0] lm_reg;
    logic [FRAC_BITS+1:0]   pos_red_reg;
    logic [FRAC_BITS+1:0]   pos_green_reg;
    logic [FRAC_BITS+1:0]   pos_blue_reg;

    // The two levels are L*M +/- S*fold, where fold is L below one half
    // and M-L from one half up.
    always_comb
    begin
        if ({lightness, 1'b0} < {1'b0, FULL})
        begin
            fold = lightness;
        end
        else
        begin
            fold = FULL - lightness;
        end
        st_next = {{FRAC_BITS{1'b0}}, saturation} * {{FRAC_BITS{1'b0}}, fold};
        lm_next = {lightness, {FRAC_BITS{1'b0}}} - {{FRAC_BITS{1'b0}}, lightness};
    end

    // Positions are counted in thirds of a hue unit, so the offsets are exact.
    always_comb
    begin
        green_wide = {2'b00, hue, 1'b0} + {3'b000, hue};
        red_wide   = green_wide + UNIT;
        blue_wide  = green_wide + UNIT_TWO;
        red_wrap   = (red_wide >= SPAN) ? red_wide - SPAN : red_wide;
        blue_wrap  = (blue_wide >= SPAN) ? blue_wide - SPAN : blue_wide;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            st_reg        <= st_next;
            lm_reg        <= lm_next;
            pos_red_reg   <= red_wrap[FRAC_BITS+1:0];
            pos_green_reg <= green_wide[FRAC_BITS+1:0];
            pos_blue_reg  <= blue_wrap[FRAC_BITS+1:0];
        end
    end

    assign st        = st_reg;
    assign lm        = lm_reg;
    assign pos_red   = pos_red_reg;
    assign pos_green = pos_green_reg;
    assign pos_blue  = pos_blue_reg;

endmodule

`default_nettype wire

>>> hdl/hsl2rgb_ramp.sv
`default_nettype none

module hsl2rgb_ramp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  hsl2rgb_pkg::ramp_ctl_t ctl,
    input  logic [2*FRAC_BITS-1:0] st,
    input  logic [2*FRAC_BITS-1:0] lm,
    input  logic [FRAC_BITS+1:0]   pos,
    output logic [2*FRAC_BITS-1:0] level
);

    import hsl2rgb_pkg::*;

    localparam logic [FRAC_BITS+1:0] HALF_UNIT  = {2'b00, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS+1:0] THREE_HALF = {2'b01, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [FRAC_BITS+1:0] TWO_UNIT   = {2'b10, {FRAC_BITS{1'b0}}};

    ramp_sel_t              sel_next;
    logic [FRAC_BITS:0]     k_next;
    logic [FRAC_BITS+1:0]   fall;
    logic [2*FRAC_BITS-1:0] v1_next;
    logic [2*FRAC_BITS-1:0] v2_next;
    logic [3*FRAC_BITS:0]   prod_next;
    logic [2*FRAC_BITS-1:0] slope;
    logic [2*FRAC_BITS-1:0] level_next;

    ramp_sel_t              sel_reg;
    logic [3*FRAC_BITS:0]   prod_reg;
    logic [2*FRAC_BITS-1:0] v1_reg;
    logic [2*FRAC_BITS-1:0] v2_reg;
    logic [2*FRAC_BITS-1:0] level_reg;

    // Rising edge below one sixth, flat high to one half, falling edge to
    // two thirds, flat low after that.
    always_comb
    begin
        fall     = TWO_UNIT - pos;
        sel_next = SEL_LOW;
        k_next   = '0;
        if (pos < HALF_UNIT)
        begin
            sel_next = SEL_RAMP;
            k_next   = {pos[FRAC_BITS-1:0], 1'b0};
        end
        else if (pos < THREE_HALF)
        begin
            sel_next = SEL_HIGH;
        end
        else if (pos < TWO_UNIT)
        begin
            sel_next = SEL_RAMP;
            k_next   = {fall[FRAC_BITS-1:0], 1'b0};
        end
        v1_next   = lm - st;
        v2_next   = lm + st;
        prod_next = {{(FRAC_BITS+1){1'b0}}, st} * {{(2*FRAC_BITS){1'b0}}, k_next};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_mul)
        begin
            sel_reg  <= sel_next;
            prod_reg <= prod_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
        end
    end

    // The level gap is twice st, so the slope term is st*k over 2^(F-1).
    always_comb
    begin
        slope = prod_reg[3*FRAC_BITS-2:FRAC_BITS-1];
        case (sel_reg)
            SEL_RAMP: level_next = v1_reg + slope;
            SEL_HIGH: level_next = v2_reg;
            SEL_LOW:  level_next = v1_reg;
            default:  level_next = v1_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_level)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

`default_nettype wire

>>> hdl/hsl2rgb_scale.sv
`default_nettype none
`include "assert_macros.svh"

module hsl2rgb_scale #(
    parameter int FRAC_BITS    = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  hsl2rgb_pkg::scale_ctl_t ctl,
    input  logic [2*FRAC_BITS-1:0]  level,
    output logic [CHANNEL_BITS-1:0] chan
);

    import hsl2rgb_pkg::*;

    localparam int NW = 2*FRAC_BITS + CHANNEL_BITS;
    localparam logic [NW-1:0] ONE     = NW'(1);
    localparam logic [NW-1:0] FULL_SQ = (ONE << (2*FRAC_BITS)) - (ONE << (FRAC_BITS+1)) + ONE;

    logic [NW-1:0]           num_next;
    logic [NW:0]             num_ext;
    logic [NW:0]             third_term;
    logic [NW:0]             est_sum;
    logic [NW-1:0]           est_prod;
    logic [NW-1:0]           rem;
    logic                    bump;
    logic [CHANNEL_BITS-1:0] chan_next;

    logic [NW-1:0]           num_reg;
    logic [NW-1:0]           num_hold_reg;
    logic [CHANNEL_BITS-1:0] est_reg;
    logic [CHANNEL_BITS-1:0] chan_reg;

    // Multiply by the channel maximum, which is a power of two less one.
    assign num_next = {level, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, level};

    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            num_reg <= num_next;
        end
    end

    // 1/M^2 = 2^-2F * (1 + 2*2^-F + 3*2^-2F + ...). Three terms give an
    // estimate that is never high and at most one below the quotient.
    always_comb
    begin
        num_ext    = {1'b0, num_reg};
        third_term = num_ext >> (2*FRAC_BITS);
        est_sum    = num_ext + ((num_ext >> FRAC_BITS) << 1) + (third_term << 1) + third_term;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_est)
        begin
            est_reg      <= est_sum[NW-1:2*FRAC_BITS];
            num_hold_reg <= num_reg;
        end
    end

    // Remainder check: E*M^2 built from shifts, one compare fixes the estimate.
    always_comb
    begin
        est_prod  = {est_reg, {(2*FRAC_BITS){1'b0}}}
                  - {{(FRAC_BITS-1){1'b0}}, est_reg, {(FRAC_BITS+1){1'b0}}}
                  + {{(2*FRAC_BITS){1'b0}}, est_reg};
        rem       = num_hold_reg - est_prod;
        bump      = (rem >= FULL_SQ);
        chan_next = est_reg + {{(CHANNEL_BITS-1){1'b0}}, bump};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

    // The estimate is off by at most one, so the remainder stays below 2*M^2.
    `HSL_ASSERT_IMP(a_est_within_one, clk, rst_n, ctl.est_valid, rem < (FULL_SQ << 1))

endmodule

`default_nettype wire

>>> hdl/hsl_to_rgb_converter.sv
// Channel   Direction  Handshake             Payload
// pixel in  input      in_valid / in_stall   hue, saturation, lightness
// pixel out output     out_valid / out_stall red, green, blue
//
// Six register stages; an accepted item raises out_valid on reaching the sixth
// and leaves when out_stall is low; one item enters per cycle when not stalled.
// Each stage carries its own valid bit, so empty stages fill while the output
// is stalled; in_stall rises only once all six stages hold items.
// Reset clears the valid bits only; data registers are not reset.
// A valid output stays put while out_stall is high.
`default_nettype none
`include "assert_macros.svh"

module hsl_to_rgb_converter #(
    parameter int FRAC_BITS    = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [FRAC_BITS-1:0]    hue,
    input  logic [FRAC_BITS-1:0]    saturation,
    input  logic [FRAC_BITS-1:0]    lightness,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue
);

    import hsl2rgb_pkg::*;

    // Stage 1: level products and hue positions.
    // Stages 2 and 3: ramp region, slope product, then the channel level.
    // Stages 4 to 6: scale to the channel range and divide by M^2.
    localparam int STAGES = 6;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] valid_next;
    logic [STAGES:1] ready;

    logic [2*FRAC_BITS-1:0] st;
    logic [2*FRAC_BITS-1:0] lm;
    logic [FRAC_BITS+1:0]   pos_red;
    logic [FRAC_BITS+1:0]   pos_green;
    logic [FRAC_BITS+1:0]   pos_blue;
    logic [2*FRAC_BITS-1:0] level_red;
    logic [2*FRAC_BITS-1:0] level_green;
    logic [2*FRAC_BITS-1:0] level_blue;

    ramp_ctl_t  ramp_ctl;
    scale_ctl_t scale_ctl;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        ready[STAGES] = !valid_reg[STAGES] || !out_stall;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[1] = ready[1] ? in_valid : valid_reg[1];
        for (int i = 2; i <= STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !ready[1];
    assign out_valid = valid_reg[STAGES];

    always_comb
    begin
        ramp_ctl.load_mul    = ready[2];
        ramp_ctl.load_level  = ready[3];
        scale_ctl.load_prod  = ready[4];
        scale_ctl.load_est   = ready[5];
        scale_ctl.load_out   = ready[6];
        scale_ctl.est_valid  = valid_reg[5];
    end

    hsl2rgb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .load       (ready[1]),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .st         (st),
        .lm         (lm),
        .pos_red    (pos_red),
        .pos_green  (pos_green),
        .pos_blue   (pos_blue)
    );

    // Red looks a third of a turn ahead, blue a third behind.
    hsl2rgb_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp_red (
        .clk   (clk),
        .ctl   (ramp_ctl),
        .st    (st),
        .lm    (lm),
        .pos   (pos_red),
        .level (level_red)
    );

    hsl2rgb_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp_green (
        .clk   (clk),
        .ctl   (ramp_ctl),
        .st    (st),
        .lm    (lm),
        .pos   (pos_green),
        .level (level_green)
    );

    hsl2rgb_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ramp_blue (
        .clk   (clk),
        .ctl   (ramp_ctl),
        .st    (st),
        .lm    (lm),
        .pos   (pos_blue),
        .level (level_blue)
    );

    hsl2rgb_scale #(
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_scale_red (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scale_ctl),
        .level (level_red),
        .chan  (red)
    );

    hsl2rgb_scale #(
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_scale_green (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scale_ctl),
        .level (level_green),
        .chan  (green)
    );

    hsl2rgb_scale #(
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_scale_blue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scale_ctl),
        .level (level_blue),
        .chan  (blue)
    );

    // An accepted item always lands in the first stage.
    `HSL_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, valid_reg[1])
    // The input is held off only when every stage is occupied.
    `HSL_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, &valid_reg)
    // A delivered item with a bubble behind it is not shown a second time.
    `HSL_ASSERT_NEXT(a_no_repeat, clk, rst_n,
        out_valid && !out_stall && !valid_reg[STAGES-1], !out_valid)

endmodule

`default_nettype wire

>>> verif/hsl_to_rgb_checker.sv
`timescale 1ns / 100ps

module hsl_to_rgb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] hue,
    input  logic [15:0] saturation,
    input  logic [15:0] lightness,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output int          mismatches,
    output int          pixels_pending,
    output int          pixels_checked
);

    localparam int         FRAC   = 16;
    localparam logic [63:0] UNIT   = 64'd65536;
    localparam logic [63:0] FULL   = 64'd65535;
    localparam logic [63:0] CH_MAX = 64'd255;

    typedef struct {
        logic [15:0] h;
        logic [15:0] s;
        logic [15:0] l;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } pixel_t;

    pixel_t expected_rgb[$];

    initial begin
        mismatches     = 0;
        pixels_pending = 0;
        pixels_checked = 0;
    end

    // Level of one channel at hue position x, counted in units of 1/(3 * 2^16).
    function automatic logic [63:0] ramp_level(input logic [63:0] v1, input logic [63:0] v2,
                                               input logic [63:0] x);
        logic [63:0] k;
        if (2 * x < UNIT)
            k = 2 * x;
        else if (2 * x < 3 * UNIT)
            return v2;
        else if (x < 2 * UNIT)
            k = 2 * (2 * UNIT - x);
        else
            return v1;
        return v1 + (((v2 - v1) * k) >> FRAC);
    endfunction

    function automatic logic [7:0] channel_byte(input logic [63:0] level);
        logic [63:0] scaled;
        scaled = (CH_MAX * level) / FULL / FULL;
        return scaled[7:0];
    endfunction

    function automatic pixel_t convert_hsl(input logic [15:0] h, input logic [15:0] s,
                                           input logic [15:0] l);
        logic [63:0] hh, ss, ll, v1, v2, xg, xr, xb;
        pixel_t px;
        hh = h;
        ss = s;
        ll = l;
        if (2 * ll < FULL)
            v2 = ll * (FULL + ss);
        else
            v2 = ll * FULL + ss * FULL - ll * ss;
        v1 = 2 * ll * FULL - v2;
        xg = 3 * hh;
        xr = xg + UNIT;
        if (xr >= 3 * UNIT)
            xr = xr - 3 * UNIT;
        xb = xg + 2 * UNIT;
        if (xb >= 3 * UNIT)
            xb = xb - 3 * UNIT;
        px.h = h;
        px.s = s;
        px.l = l;
        px.r = channel_byte(ramp_level(v1, v2, xr));
        px.g = channel_byte(ramp_level(v1, v2, xg));
        px.b = channel_byte(ramp_level(v1, v2, xb));
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want,
                                   input pixel_t px);
        $display("[%0t] %s wrong: got %0d, want %0d (hue %h sat %h light %h)",
                 $realtime, what, got, want, px.h, px.s, px.l);
        mismatches++;
    endtask

    always @(posedge clk) begin
        pixel_t want;
        if (rst_n) begin
            // The result leaving at this edge is always older than any item entering.
            if (out_valid && !out_stall) begin
                if (expected_rgb.size() == 0) begin
                    want = '{default: '0};
                    report_mismatch("unexpected result", 1, 0, want);
                end
                else begin
                    want = expected_rgb.pop_front();
                    if (red !== want.r)
                        report_mismatch("red", red, want.r, want);
                    if (green !== want.g)
                        report_mismatch("green", green, want.g, want);
                    if (blue !== want.b)
                        report_mismatch("blue", blue, want.b, want);
                    pixels_checked++;
                end
            end
            if (in_valid && !in_stall)
                expected_rgb.push_back(convert_hsl(hue, saturation, lightness));
            pixels_pending = expected_rgb.size();
        end
    end

endmodule

>>> verif/hsl_to_rgb_converter_test.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the HSL to RGB converter. The checker beside the
// block watches both channels, predicts each pixel and compares; this module
// only produces pixels, applies back pressure and decides the outcome.
module hsl_to_rgb_converter_test;

    // A quarter of the random items go into each pressure phase.
    localparam int ITEMS_PER_PHASE = 400;
    // Six stages deep, so this quiet wait is plenty to flush stragglers.
    localparam int DRAIN_CYCLES    = 12;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [15:0] hue        = '0;
    logic [15:0] saturation = '0;
    logic [15:0] lightness  = '0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    int mismatches;
    int pixels_pending;
    int pixels_checked;

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hsl_to_rgb_converter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    hsl_to_rgb_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .hue            (hue),
        .saturation     (saturation),
        .lightness      (lightness),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .mismatches     (mismatches),
        .pixels_pending (pixels_pending),
        .pixels_checked (pixels_checked)
    );

    // The receiver decides its stall afresh at every falling edge.
    always @(negedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Offers one pixel and returns once the block has taken it. Valid stays
    // high afterwards, so back-to-back items follow without a gap; it drops only
    // when the sender decides to idle at a later falling edge or drain_pipeline stops sending.
    task automatic send_pixel(input logic [15:0] h, input logic [15:0] s,
                              input logic [15:0] l);
        @(negedge clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        hue        <= h;
        saturation <= s;
        lightness  <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Stops sending and waits until every predicted pixel has come out.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels_pending != 0)
            @(posedge clk);
    endtask

    // Hue values at and around the edges of the ramp pieces: zero, one sixth,
    // one third, one half, two thirds and the top of the range.
    function automatic logic [15:0] hue_mark();
        logic [15:0] marks [6];
        marks = '{16'h0000, 16'h2AAB, 16'h5555, 16'h8000, 16'hAAAB, 16'hFFFF};
        return marks[$urandom_range(5)] + 16'($urandom_range(4)) - 16'd2;
    endfunction

    // Most values are uniform; the rest sit on the corners where the
    // arithmetic changes branch (zero, one, and lightness around one half).
    function automatic logic [15:0] pick_level(input bit is_hue);
        case ($urandom_range(9))
            0:       return is_hue ? hue_mark() : 16'h0000;
            1:       return is_hue ? hue_mark() : 16'hFFFF;
            2:       return is_hue ? hue_mark() : 16'h7FFE + 16'($urandom_range(3));
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        logic [15:0] directed_px [22][3];
        int directed_count;

        // Corners of all three fields, grey pixels, every hue piece on both
        // sides of its boundary, the hue wrap and lightness across one half.
        directed_px = '{
            '{16'h0000, 16'h0000, 16'h0000},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'h0000, 16'h0000, 16'hFFFF},
            '{16'h1234, 16'h0000, 16'h8000},
            '{16'hFFFF, 16'h0000, 16'h7FFF},
            '{16'h0000, 16'hFFFF, 16'h8000},
            '{16'h0000, 16'hFFFF, 16'h7FFF},
            '{16'h2AAA, 16'hFFFF, 16'h8000},
            '{16'h2AAB, 16'hFFFF, 16'h8000},
            '{16'h5555, 16'hFFFF, 16'h8000},
            '{16'h5556, 16'hFFFF, 16'h8000},
            '{16'h7FFF, 16'hFFFF, 16'h8000},
            '{16'h8000, 16'hFFFF, 16'h8000},
            '{16'hAAAA, 16'hFFFF, 16'h8000},
            '{16'hAAAB, 16'hFFFF, 16'h8000},
            '{16'hD555, 16'hFFFF, 16'h8000},
            '{16'hFFFF, 16'hFFFF, 16'h8000},
            '{16'hFFFF, 16'hFFFF, 16'h0000},
            '{16'h4000, 16'h8000, 16'h3FFF},
            '{16'hC000, 16'h8000, 16'hC000},
            '{16'h5555, 16'hAAAA, 16'hFFFE},
            '{16'hAAAA, 16'h5555, 16'h0001}
        };
        directed_count = $size(directed_px);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_px[i])
            send_pixel(directed_px[i][0], directed_px[i][1], directed_px[i][2]);
        drain_pipeline();

        // Four pressure phases: free running, slow sender, slow receiver, and
        // light idling on both sides. The pipeline is emptied between phases,
        // so the block also sees a cold start each time.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 65; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_pixel(pick_level(1'b1), pick_level(1'b0), pick_level(1'b0));
            drain_pipeline();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d directed corners, the rest random) under four",
                 items_sent, directed_count);
        $display("handshake pressure phases; %0d converted pixels were compared.",
                 pixels_checked);
        if (mismatches == 0)
            $display("hsl_to_rgb_converter: match");
        else
            $display("hsl_to_rgb_converter: mismatch");
        $finish;
    end

    // Even the slowest phases finish well within this time limit.
    initial
    begin
        #2ms;
        $display("hsl_to_rgb_converter: mismatch");
        $finish;
    end

endmodule
